[sv/scale_button_note_mapper_assert.svh]
// Assertion macros for the scale button note mapper datapath.
`ifndef SCALE_BUTTON_NOTE_MAPPER_ASSERT_SVH
`define SCALE_BUTTON_NOTE_MAPPER_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define SBNM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sbnm: invariant violated");

// Checks a same-cycle implication.
`define SBNM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbnm: implication violated");

// Checks a next-cycle implication.
`define SBNM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbnm: next-cycle implication violated");

`endif

[sv/sbnm_pkg.sv]
// Types, constants and helper functions of the scale button note mapper.
package sbnm_pkg;

  localparam int NOTE_BUTTONS = 12;
  localparam int IDX_W        = $clog2(NOTE_BUTTONS);

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_FIRST_BUTTON = 3'd0;
  localparam logic [2:0] REG_KEY_MODE     = 3'd1;
  localparam logic [2:0] REG_LOWEST_MODE  = 3'd2;
  localparam logic [2:0] REG_SHIFT_X      = 3'd3;
  localparam logic [2:0] REG_SHIFT_Y      = 3'd4;

  localparam logic [6:0] RST_FIRST_BUTTON = 7'd64;
  localparam logic [6:0] RST_KEY_MODE     = 7'd63;
  localparam logic [6:0] RST_LOWEST_MODE  = 7'd62;
  localparam logic [6:0] RST_SHIFT_X      = 7'd18;
  localparam logic [6:0] RST_SHIFT_Y      = 7'd19;

  // Input actions.
  localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [1:0] ACT_CTRL     = 2'd2;

  // Joystick positions.
  localparam logic [1:0] POS_CENTRE = 2'd0;
  localparam logic [1:0] POS_UP     = 2'd1;
  localparam logic [1:0] POS_DOWN   = 2'd2;

  // Item classes reported by the datapath.
  localparam logic [2:0] CLS_NONE     = 3'd0;
  localparam logic [2:0] CLS_BUTTON   = 3'd1;
  localparam logic [2:0] CLS_KEY_NOTE = 3'd2;
  localparam logic [2:0] CLS_LOW_NOTE = 3'd3;
  localparam logic [2:0] CLS_STICK    = 3'd4;

  localparam logic [6:0] OCT_STEP    = 7'd12;
  localparam logic [6:0] OCT_MIN     = 7'd12;
  localparam logic [6:0] OCT_MAX     = 7'd96;
  localparam logic [6:0] OCT_RESET   = 7'd60;
  localparam logic [6:0] STICK_RESET = 7'd64;
  localparam logic [6:0] STICK_LO    = 7'd32;
  localparam logic [6:0] STICK_HI    = 7'd96;
  localparam logic [6:0] CENTRE_LO   = 7'd48;
  localparam logic [6:0] CENTRE_HI   = 7'd80;
  localparam logic [6:0] VEL_ON      = 7'd127;
  localparam logic [6:0] VEL_OFF     = 7'd0;
  localparam logic       KIND_OFF    = 1'b0;
  localparam logic       KIND_ON     = 1'b1;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] note_or_param;
    logic [6:0] value;
  } in_item_t;

  typedef struct packed {
    logic       out_kind;
    logic [6:0] out_note;
    logic [6:0] out_velocity;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [6:0] first_button_note;
    logic [6:0] key_mode_note;
    logic [6:0] lowest_mode_note;
    logic [6:0] shift_x_controller;
    logic [6:0] shift_y_controller;
  } cfg_t;

  typedef struct packed {
    logic             load_item;
    logic             set_key;
    logic             set_lowest;
    logic             set_key_mode;
    logic             set_low_mode;
    logic             press;
    logic             release_btn;
    logic             stick_store;
    logic             y_apply;
    logic             x_apply;
    logic             rt_off;
    logic             rt_on;
    logic             flush;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cls;
    logic       pressed;
    logic       key_mode;
    logic       lowest_mode;
    logic       y_chg;
    logic       x_chg;
    logic       rt_hit;
    logic       emit_ok;
    logic       pend_valid;
    logic       out_free;
  } dp_sts_t;

  // Scale degree of each note button.
  function automatic logic [IDX_W-1:0] degree_of_button(input logic [IDX_W-1:0] b);
    logic [IDX_W-1:0] d;
    case (b)
      4'd0:    d = 4'd10;
      4'd1:    d = 4'd11;
      4'd2:    d = 4'd5;
      4'd3:    d = 4'd4;
      4'd4:    d = 4'd8;
      4'd5:    d = 4'd9;
      4'd6:    d = 4'd3;
      4'd7:    d = 4'd2;
      4'd8:    d = 4'd6;
      4'd9:    d = 4'd7;
      4'd10:   d = 4'd1;
      4'd11:   d = 4'd0;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

endpackage

[sv/sbnm_cfg.sv]
// Configuration register file with its APB-style access port.
module sbnm_cfg import sbnm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;
  logic [6:0] rd_val;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_FIRST_BUTTON: cfg_nxt.first_button_note  = pwdata[6:0];
        REG_KEY_MODE:     cfg_nxt.key_mode_note      = pwdata[6:0];
        REG_LOWEST_MODE:  cfg_nxt.lowest_mode_note   = pwdata[6:0];
        REG_SHIFT_X:      cfg_nxt.shift_x_controller = pwdata[6:0];
        REG_SHIFT_Y:      cfg_nxt.shift_y_controller = pwdata[6:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FIRST_BUTTON: rd_val = cfg_r.first_button_note;
      REG_KEY_MODE:     rd_val = cfg_r.key_mode_note;
      REG_LOWEST_MODE:  rd_val = cfg_r.lowest_mode_note;
      REG_SHIFT_X:      rd_val = cfg_r.shift_x_controller;
      REG_SHIFT_Y:      rd_val = cfg_r.shift_y_controller;
      default:          rd_val = 7'd0;
    endcase
  end

  assign prdata = {{(CFG_DW-7){1'b0}}, rd_val};
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_button_note  <= RST_FIRST_BUTTON;
      cfg_r.key_mode_note      <= RST_KEY_MODE;
      cfg_r.lowest_mode_note   <= RST_LOWEST_MODE;
      cfg_r.shift_x_controller <= RST_SHIFT_X;
      cfg_r.shift_y_controller <= RST_SHIFT_Y;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[sv/sbnm_dp.sv]
// Datapath: mapper state, pitch arithmetic and the result pipeline.
`include "scale_button_note_mapper_assert.svh"

module sbnm_dp import sbnm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data
);

  in_item_t         item_r;
  logic             held_valid_r [NOTE_BUTTONS];
  logic [6:0]       held_note_r  [NOTE_BUTTONS];
  logic [IDX_W-1:0] key_offset_r, key_offset_nxt;
  logic [IDX_W-1:0] lowest_degree_r, lowest_degree_nxt;
  logic [6:0]       octave_base_r, octave_base_nxt;
  logic             key_mode_r, key_mode_nxt;
  logic             lowest_mode_r, lowest_mode_nxt;
  logic [1:0]       shift_x_r, shift_x_nxt;
  logic [1:0]       shift_y_r, shift_y_nxt;
  logic [6:0]       stick_x_r, stick_x_nxt;
  logic [6:0]       stick_y_r, stick_y_nxt;
  out_item_t        pend_r, pend_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [7:0]       btn_diff;
  logic             in_range;
  logic [IDX_W-1:0] btn_deg;
  logic             pressed;
  logic [6:0]       p_btn;
  logic [6:0]       p_rt;
  logic [1:0]       y_tgt, x_tgt;
  logic             y_chg, x_chg;
  logic [6:0]       oct_up, oct_dn;
  logic             emit;
  out_item_t        new_item;
  logic             out_free;

  function automatic logic [6:0] pitch_of(input logic [6:0] oct, input logic [IDX_W-1:0] key,
                                          input logic [IDX_W-1:0] low,
                                          input logic [IDX_W-1:0] d);
    logic [7:0] s;
    s = {1'b0, oct} + 8'(key) + 8'(d);
    if (d < low) s = s - 8'(OCT_STEP);
    return s[6:0];
  endfunction

  function automatic logic [1:0] stick_target(input logic [6:0] v, input logic [1:0] cur);
    logic [1:0] t;
    if (v < STICK_LO)                        t = POS_DOWN;
    else if (v > STICK_HI)                   t = POS_UP;
    else if (v > CENTRE_LO && v < CENTRE_HI) t = POS_CENTRE;
    else                                     t = cur;
    return t;
  endfunction

  // Button decode against the configured range.
  assign btn_diff = {1'b0, item_r.note_or_param} - {1'b0, cfg.first_button_note};
  assign in_range = (item_r.note_or_param >= cfg.first_button_note) &&
                    (btn_diff < 8'(NOTE_BUTTONS));
  assign btn_deg  = degree_of_button(btn_diff[IDX_W-1:0]);
  assign pressed  = (item_r.action == ACT_NOTE_ON) && (item_r.value != 7'd0);

  assign p_btn = pitch_of(octave_base_r, key_offset_r, lowest_degree_r, btn_deg);
  assign p_rt  = pitch_of(octave_base_r, key_offset_r, lowest_degree_r, cmd.idx);

  assign oct_up = (octave_base_r + OCT_STEP > OCT_MAX) ? OCT_MAX : octave_base_r + OCT_STEP;
  assign oct_dn = (octave_base_r < OCT_MIN + OCT_STEP) ? OCT_MIN : octave_base_r - OCT_STEP;

  assign y_tgt = stick_target(stick_y_r, shift_y_r);
  assign x_tgt = stick_target(stick_x_r, shift_x_r);
  assign y_chg = (y_tgt != POS_CENTRE) && (y_tgt != shift_y_r);
  assign x_chg = (x_tgt != shift_x_r);

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    sts.cls = CLS_NONE;
    if (item_r.action == ACT_NOTE_ON || item_r.action == ACT_NOTE_OFF) begin
      if (in_range)                                        sts.cls = CLS_BUTTON;
      else if (item_r.note_or_param == cfg.key_mode_note)    sts.cls = CLS_KEY_NOTE;
      else if (item_r.note_or_param == cfg.lowest_mode_note) sts.cls = CLS_LOW_NOTE;
    end else if (item_r.action == ACT_CTRL) begin
      if (item_r.note_or_param == cfg.shift_x_controller ||
          item_r.note_or_param == cfg.shift_y_controller) sts.cls = CLS_STICK;
    end
    sts.pressed     = pressed;
    sts.key_mode    = key_mode_r;
    sts.lowest_mode = lowest_mode_r;
    sts.y_chg       = y_chg;
    sts.x_chg       = x_chg;
    sts.rt_hit      = held_valid_r[cmd.idx] && (held_note_r[cmd.idx] != p_rt);
    sts.emit_ok     = !pend_valid_r || out_free;
    sts.pend_valid  = pend_valid_r;
    sts.out_free    = out_free;
  end

  // Settings, octave and joystick state.
  always_comb begin
    key_offset_nxt    = key_offset_r;
    lowest_degree_nxt = lowest_degree_r;
    key_mode_nxt      = key_mode_r;
    lowest_mode_nxt   = lowest_mode_r;
    octave_base_nxt   = octave_base_r;
    shift_x_nxt       = shift_x_r;
    shift_y_nxt       = shift_y_r;
    stick_x_nxt       = stick_x_r;
    stick_y_nxt       = stick_y_r;
    if (cmd.set_key)      key_offset_nxt    = btn_deg;
    if (cmd.set_lowest)   lowest_degree_nxt = btn_deg;
    if (cmd.set_key_mode) key_mode_nxt      = pressed;
    if (cmd.set_low_mode) lowest_mode_nxt   = pressed;
    if (cmd.stick_store) begin
      if (item_r.note_or_param == cfg.shift_x_controller) stick_x_nxt = item_r.value;
      else                                                stick_y_nxt = item_r.value;
    end
    if (cmd.y_apply) begin
      shift_y_nxt = y_tgt;
      if (y_chg) octave_base_nxt = (y_tgt == POS_UP) ? oct_up : oct_dn;
    end
    if (cmd.x_apply) begin
      shift_x_nxt = x_tgt;
      if (x_chg) begin
        case (x_tgt)
          POS_UP:     octave_base_nxt = oct_up;
          POS_DOWN:   octave_base_nxt = oct_dn;
          POS_CENTRE: octave_base_nxt = (shift_x_r == POS_UP) ? oct_dn : oct_up;
          default:    octave_base_nxt = octave_base_r;
        endcase
      end
    end
  end

  // Result selection, then a one-deep pending slot ahead of the output register.
  // The pending slot lets the last result of a transaction be marked once it is known.
  assign emit = cmd.press | cmd.release_btn | cmd.rt_off | cmd.rt_on;

  always_comb begin
    new_item.last = 1'b0;
    if (cmd.press) begin
      new_item.out_kind = KIND_ON;
      new_item.out_note = p_btn;
    end else if (cmd.release_btn) begin
      new_item.out_kind = KIND_OFF;
      new_item.out_note = held_valid_r[btn_deg] ? held_note_r[btn_deg] : p_btn;
    end else if (cmd.rt_off) begin
      new_item.out_kind = KIND_OFF;
      new_item.out_note = held_note_r[cmd.idx];
    end else begin
      new_item.out_kind = KIND_ON;
      new_item.out_note = p_rt;
    end
    new_item.out_velocity = new_item.out_kind ? VEL_ON : VEL_OFF;
  end

  always_comb begin
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    if (emit) begin
      if (pend_valid_r) begin
        out_nxt       = pend_r;
        out_valid_nxt = 1'b1;
      end
      pend_nxt       = new_item;
      pend_valid_nxt = 1'b1;
    end else if (cmd.flush && pend_valid_r && out_free) begin
      out_nxt        = pend_r;
      out_nxt.last   = 1'b1;
      out_valid_nxt  = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    if (cmd.press)  held_note_r[btn_deg] <= p_btn;
    if (cmd.rt_on)  held_note_r[cmd.idx] <= p_rt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NOTE_BUTTONS; i++) held_valid_r[i] <= 1'b0;
      key_offset_r    <= '0;
      lowest_degree_r <= '0;
      octave_base_r   <= OCT_RESET;
      key_mode_r      <= 1'b0;
      lowest_mode_r   <= 1'b0;
      shift_x_r       <= POS_CENTRE;
      shift_y_r       <= POS_CENTRE;
      stick_x_r       <= STICK_RESET;
      stick_y_r       <= STICK_RESET;
      pend_valid_r    <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cmd.press)       held_valid_r[btn_deg] <= 1'b1;
      if (cmd.release_btn) held_valid_r[btn_deg] <= 1'b0;
      key_offset_r    <= key_offset_nxt;
      lowest_degree_r <= lowest_degree_nxt;
      octave_base_r   <= octave_base_nxt;
      key_mode_r      <= key_mode_nxt;
      lowest_mode_r   <= lowest_mode_nxt;
      shift_x_r       <= shift_x_nxt;
      shift_y_r       <= shift_y_nxt;
      stick_x_r       <= stick_x_nxt;
      stick_y_r       <= stick_y_nxt;
      pend_valid_r    <= pend_valid_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  `SBNM_ASSERT_ALWAYS(a_octave_range, octave_base_r >= OCT_MIN && octave_base_r <= OCT_MAX)
  `SBNM_ASSERT_ALWAYS(a_key_range, key_offset_r < 4'(NOTE_BUTTONS))
  `SBNM_ASSERT_ALWAYS(a_lowest_range, lowest_degree_r < 4'(NOTE_BUTTONS))
  `SBNM_ASSERT_IMPL(a_emit_has_room, emit && pend_valid_r, out_free)
  `SBNM_ASSERT_NEXT(a_flush_drains, cmd.flush && out_free && !emit, !pend_valid_r)

endmodule

[sv/sbnm_ctrl.sv]
// Controller: sequences decode, joystick handling and the retune sweep.
module sbnm_ctrl import sbnm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DECODE   = 3'd1;
  localparam logic [2:0] ST_STICK_Y  = 3'd2;
  localparam logic [2:0] ST_STICK_X  = 3'd3;
  localparam logic [2:0] ST_RT_CHECK = 3'd4;
  localparam logic [2:0] ST_RT_ON    = 3'd5;
  localparam logic [2:0] ST_FINISH   = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             ret_x_r, ret_x_nxt;
  logic             cnt_end;
  logic [2:0]       ret_state;

  assign cnt_end   = (cnt_r == IDX_W'(NOTE_BUTTONS - 1));
  assign ret_state = ret_x_r ? ST_STICK_X : ST_FINISH;
  assign in_stall  = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ret_x_nxt = ret_x_r;
    cmd       = '0;
    cmd.idx   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.cls)
          CLS_BUTTON: begin
            if (sts.key_mode || sts.lowest_mode) begin
              state_nxt = ST_FINISH;
              if (sts.pressed) begin
                cmd.set_key    = sts.key_mode;
                cmd.set_lowest = !sts.key_mode;
                cnt_nxt        = '0;
                ret_x_nxt      = 1'b0;
                state_nxt      = ST_RT_CHECK;
              end
            end else if (sts.emit_ok) begin
              cmd.press       = sts.pressed;
              cmd.release_btn = !sts.pressed;
              state_nxt       = ST_FINISH;
            end
          end
          CLS_KEY_NOTE: begin
            cmd.set_key_mode = 1'b1;
            state_nxt        = ST_FINISH;
          end
          CLS_LOW_NOTE: begin
            cmd.set_low_mode = 1'b1;
            state_nxt        = ST_FINISH;
          end
          CLS_STICK: begin
            cmd.stick_store = 1'b1;
            state_nxt       = ST_STICK_Y;
          end
          default: state_nxt = ST_FINISH;
        endcase
      end
      ST_STICK_Y: begin
        cmd.y_apply = 1'b1;
        if (sts.y_chg) begin
          cnt_nxt   = '0;
          ret_x_nxt = 1'b1;
          state_nxt = ST_RT_CHECK;
        end else begin
          state_nxt = ST_STICK_X;
        end
      end
      ST_STICK_X: begin
        cmd.x_apply = 1'b1;
        if (sts.x_chg) begin
          cnt_nxt   = '0;
          ret_x_nxt = 1'b0;
          state_nxt = ST_RT_CHECK;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_RT_CHECK: begin
        if (sts.rt_hit) begin
          if (sts.emit_ok) begin
            cmd.rt_off = 1'b1;
            state_nxt  = ST_RT_ON;
          end
        end else if (cnt_end) begin
          state_nxt = ret_state;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_RT_ON: begin
        if (sts.emit_ok) begin
          cmd.rt_on = 1'b1;
          if (cnt_end) begin
            state_nxt = ret_state;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = ST_RT_CHECK;
          end
        end
      end
      ST_FINISH: begin
        cmd.flush = 1'b1;
        if (!sts.pend_valid || sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ret_x_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ret_x_r <= ret_x_nxt;
    end
  end

endmodule

[sv/scale_button_note_mapper.sv]
// Top level of the scale button note mapper.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  in_item_t: action, note_or_param, value
//   out_     output     out_valid/out_stall out_item_t: out_kind, out_note, out_velocity, last
//   cfg_     input      APB-style write/read 32-bit data, five 7-bit registers at 4*i
//
// A transaction on the input that causes no retune steps through accept,
// decode and finish, plus a step per joystick axis for controller changes.
// A retune sweeps the twelve held entries one per cycle through the retune
// pitch adder, with an extra step for each held note that moved. Reset is
// synchronous and active low and clears the hold flags and all settings;
// held pitches are only read behind their hold flag, so no clearing pass is
// needed. A stall on the output holds the sweep whenever both the output
// register and the pending slot are full.
//
// Results of one transaction leave through a one-deep pending slot so the final
// result can carry last before it is presented. The next input transaction is
// taken only after the previous one has flushed its last result to the output
// register; the output register may still be waiting for the receiver then.
module scale_button_note_mapper import sbnm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // The register file always completes an access without wait states.
  assign cfg_pready = 1'b1;

  sbnm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // The controller steps through each transaction and drives the datapath by command.
  sbnm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the notes, settings and joystick state and builds the results.
  sbnm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[bench/sbnm_checker.sv]
// Scoreboard for the scale button note mapper: tracks mapper state, predicts and compares.
module sbnm_checker import sbnm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic              cfg_pready,
  output int                fail_count,
  output int                expected_left,
  output int                results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [6:0] first_btn;
  logic [6:0] key_btn;
  logic [6:0] low_btn;
  logic [6:0] x_ctrl;
  logic [6:0] y_ctrl;

  logic       held_on    [NOTE_BUTTONS];
  logic [6:0] held_pitch [NOTE_BUTTONS];
  int         key_ofs;
  int         low_deg;
  int         oct_base;
  int         x_val;
  int         y_val;
  logic [1:0] x_pos;
  logic [1:0] y_pos;
  logic       key_arm;
  logic       low_arm;

  out_item_t  due_notes [$];

  function automatic int button_degree(int b);
    case (b)
      0:       return 10;
      1:       return 11;
      2:       return 5;
      3:       return 4;
      4:       return 8;
      5:       return 9;
      6:       return 3;
      7:       return 2;
      8:       return 6;
      9:       return 7;
      10:      return 1;
      default: return 0;
    endcase
  endfunction

  // Degrees below the lowest degree drop an octave.
  function automatic logic [6:0] pitch_now(int d);
    int p;
    p = oct_base + key_ofs + d;
    if (d < low_deg) p = p - 12;
    return p[6:0];
  endfunction

  task automatic queue_note(logic on, logic [6:0] n);
    out_item_t r;
    r.out_kind     = on ? KIND_ON : KIND_OFF;
    r.out_note     = n;
    r.out_velocity = on ? VEL_ON : VEL_OFF;
    r.last         = 1'b0;
    due_notes.push_back(r);
  endtask

  task automatic retune_held();
    logic [6:0] p;
    for (int d = 0; d < NOTE_BUTTONS; d++) begin
      if (held_on[d]) begin
        p = pitch_now(d);
        if (held_pitch[d] != p) begin
          queue_note(1'b0, held_pitch[d]);
          held_pitch[d] = p;
          queue_note(1'b1, p);
        end
      end
    end
  endtask

  task automatic octave_up();
    oct_base = (oct_base + OCT_STEP > OCT_MAX) ? OCT_MAX : oct_base + OCT_STEP;
  endtask

  task automatic octave_down();
    oct_base = (oct_base < OCT_MIN + OCT_STEP) ? OCT_MIN : oct_base - OCT_STEP;
  endtask

  // The y axis jumps once per excursion; the x axis shifts while held and
  // undoes the shift when it comes back to the centre band.
  task automatic follow_stick();
    if (y_val < STICK_LO) begin
      if (y_pos != POS_DOWN) begin
        y_pos = POS_DOWN;
        octave_down();
        retune_held();
      end
    end else if (y_val > STICK_HI) begin
      if (y_pos != POS_UP) begin
        y_pos = POS_UP;
        octave_up();
        retune_held();
      end
    end else if (y_val > CENTRE_LO && y_val < CENTRE_HI) begin
      y_pos = POS_CENTRE;
    end

    if (x_val < STICK_LO) begin
      if (x_pos != POS_DOWN) begin
        x_pos = POS_DOWN;
        octave_down();
        retune_held();
      end
    end else if (x_val > STICK_HI) begin
      if (x_pos != POS_UP) begin
        x_pos = POS_UP;
        octave_up();
        retune_held();
      end
    end else if (x_val > CENTRE_LO && x_val < CENTRE_HI) begin
      if (x_pos != POS_CENTRE) begin
        if (x_pos == POS_UP) octave_down();
        else octave_up();
        x_pos = POS_CENTRE;
        retune_held();
      end
    end
  endtask

  task automatic button_event(int n, logic pressed);
    int d;
    if (n >= first_btn && n < first_btn + NOTE_BUTTONS) begin
      d = button_degree(n - first_btn);
      if (key_arm) begin
        if (pressed) begin
          key_ofs = d;
          retune_held();
        end
      end else if (low_arm) begin
        if (pressed) begin
          low_deg = d;
          retune_held();
        end
      end else if (pressed) begin
        held_on[d]    = 1'b1;
        held_pitch[d] = pitch_now(d);
        queue_note(1'b1, held_pitch[d]);
      end else begin
        queue_note(1'b0, held_on[d] ? held_pitch[d] : pitch_now(d));
        held_on[d] = 1'b0;
      end
    end else if (n == key_btn) begin
      key_arm = pressed;
    end else if (n == low_btn) begin
      low_arm = pressed;
    end
  endtask

  task automatic predict_item(in_item_t it);
    int        queued_before;
    out_item_t r;
    queued_before = due_notes.size();
    case (it.action)
      ACT_NOTE_ON:  button_event(it.note_or_param, it.value != 7'd0);
      ACT_NOTE_OFF: button_event(it.note_or_param, 1'b0);
      ACT_CTRL: begin
        if (it.note_or_param == x_ctrl) begin
          x_val = it.value;
          follow_stick();
        end else if (it.note_or_param == y_ctrl) begin
          y_val = it.value;
          follow_stick();
        end
      end
      default: ;
    endcase
    if (due_notes.size() > queued_before) begin
      r      = due_notes.pop_back();
      r.last = 1'b1;
      due_notes.push_back(r);
    end
  endtask

  task automatic clear_model();
    first_btn = RST_FIRST_BUTTON;
    key_btn   = RST_KEY_MODE;
    low_btn   = RST_LOWEST_MODE;
    x_ctrl    = RST_SHIFT_X;
    y_ctrl    = RST_SHIFT_Y;
    for (int d = 0; d < NOTE_BUTTONS; d++) begin
      held_on[d]    = 1'b0;
      held_pitch[d] = 7'd0;
    end
    key_ofs  = 0;
    low_deg  = 0;
    oct_base = OCT_RESET;
    x_val    = STICK_RESET;
    y_val    = STICK_RESET;
    x_pos    = POS_CENTRE;
    y_pos    = POS_CENTRE;
    key_arm  = 1'b0;
    low_arm  = 1'b0;
    due_notes.delete();
  endtask

  task automatic compare_field(string name, logic [6:0] want, logic [6:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      clear_model();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_AW-1:2])
          REG_FIRST_BUTTON: first_btn = cfg_pwdata[6:0];
          REG_KEY_MODE:     key_btn   = cfg_pwdata[6:0];
          REG_LOWEST_MODE:  low_btn   = cfg_pwdata[6:0];
          REG_SHIFT_X:      x_ctrl    = cfg_pwdata[6:0];
          REG_SHIFT_Y:      y_ctrl    = cfg_pwdata[6:0];
          default: ;
        endcase
      end
      // Results leave before a new input in the same cycle can cause any.
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_notes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got kind %0d note %0d vel %0d last %0d",
                   $time, out_data.out_kind, out_data.out_note, out_data.out_velocity,
                   out_data.last);
        end else begin
          want = due_notes.pop_front();
          compare_field("out_kind", want.out_kind, out_data.out_kind);
          compare_field("out_note", want.out_note, out_data.out_note);
          compare_field("out_velocity", want.out_velocity, out_data.out_velocity);
          compare_field("last", want.last, out_data.last);
        end
      end
      if (in_valid && !in_stall) predict_item(in_data);
    end
    expected_left <= due_notes.size();
  end

endmodule

[bench/tb_top.sv]
// Top of the scale button note mapper bench: clock, reset, stimulus and verdict.
module tb_top import sbnm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // The package names no code for the fourth action; the block must ignore it.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Cycles the block may still be busy after its last result has left. A
  // transaction that sends nothing can still sweep twice, once per axis, on top
  // of its decode, axis and finish steps.
  localparam int SETTLE_CYCLES = 40;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  in_item_t          in_data     = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  out_item_t         out_data;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int fail_count;
  int expected_left;
  int results_seen;

  // While calm is set neither side inserts idle cycles.
  logic calm       = 1'b0;
  int   sent_items = 0;
  int   setups     = 0;

  // Our copy of the register values, used to aim the stimulus at live numbers.
  logic [6:0] cur_first;
  logic [6:0] cur_key;
  logic [6:0] cur_low;
  logic [6:0] cur_x;
  logic [6:0] cur_y;

  scale_button_note_mapper u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  sbnm_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .fail_count    (fail_count),
    .expected_left (expected_left),
    .results_seen  (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver stalls at random with a chance of 9 in 100, never while calm.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 9);
  end

  function automatic in_item_t mk(logic [1:0] act, logic [6:0] num, logic [6:0] val);
    in_item_t it;
    it.action        = act;
    it.note_or_param = num;
    it.value         = val;
    return it;
  endfunction

  // Offers one transaction and returns right after the edge that took it.
  // Idle cycles before the offer keep valid low; the payload stays put
  // while the block stalls.
  task automatic send_item(in_item_t it);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  // Setup phase and access phase, then an idle phase so that back-to-back
  // writes never assign psel twice in one time step.
  task automatic write_reg(logic [2:0] idx, logic [6:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {{(CFG_DW-7){1'b0}}, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setup(logic [6:0] first, logic [6:0] key, logic [6:0] low,
                             logic [6:0] x, logic [6:0] y);
    write_reg(REG_FIRST_BUTTON, first);
    write_reg(REG_KEY_MODE, key);
    write_reg(REG_LOWEST_MODE, low);
    write_reg(REG_SHIFT_X, x);
    write_reg(REG_SHIFT_Y, y);
    cur_first = first;
    cur_key   = key;
    cur_low   = low;
    cur_x     = x;
    cur_y     = y;
    setups++;
  endtask

  // Drops valid, waits for every predicted result, then lets the block finish
  // any transaction that produced nothing.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed traffic: button presses and releases aimed at the
  // current button range, mode buttons that are usually released, and stick
  // moves biased into the down, up and centre bands. The rest is noise over
  // every field, including the unused action.
  function automatic in_item_t next_random_item();
    in_item_t   it;
    int         pick;
    logic [6:0] v;
    pick = $urandom_range(99);
    if (pick < 34) begin
      it = mk(ACT_NOTE_ON, 7'(cur_first + $urandom_range(0, 11)), 7'($urandom_range(1, 127)));
    end else if (pick < 58) begin
      if ($urandom_range(1))
        it = mk(ACT_NOTE_OFF, 7'(cur_first + $urandom_range(0, 11)), 7'($urandom_range(0, 127)));
      else
        it = mk(ACT_NOTE_ON, 7'(cur_first + $urandom_range(0, 11)), 7'd0);
    end else if (pick < 74) begin
      v = (pick < 66) ? cur_key : cur_low;
      if ($urandom_range(99) < 35)
        it = mk(ACT_NOTE_ON, v, 7'($urandom_range(1, 127)));
      else if ($urandom_range(1))
        it = mk(ACT_NOTE_OFF, v, 7'($urandom_range(0, 127)));
      else
        it = mk(ACT_NOTE_ON, v, 7'd0);
    end else if (pick < 91) begin
      case ($urandom_range(3))
        0:       v = 7'($urandom_range(0, 31));
        1:       v = 7'($urandom_range(97, 127));
        2:       v = 7'($urandom_range(49, 79));
        default: v = 7'($urandom_range(0, 127));
      endcase
      it = mk(ACT_CTRL, $urandom_range(1) ? cur_x : cur_y, v);
    end else begin
      it = mk(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    end
    return it;
  endfunction

  task automatic play_random(int n);
    repeat (n) send_item(next_random_item());
  endtask

  initial begin
    logic [6:0] shared_note;
    logic [6:0] shared_ctrl;

    // Synchronous reset, held low from the start and applied once.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: the reset values written explicitly, then a directed walk
    // with buttons 64..75, key mode on 63, lowest mode on 62, x on 18, y on 19.
    apply_setup(RST_FIRST_BUTTON, RST_KEY_MODE, RST_LOWEST_MODE, RST_SHIFT_X, RST_SHIFT_Y);

    send_item(mk(ACT_NOTE_ON, 7'd64, 7'd127));  // first button, highest degree but one
    send_item(mk(ACT_NOTE_ON, 7'd75, 7'd1));    // last button, degree zero, softest press
    send_item(mk(ACT_NOTE_ON, 7'd64, 7'd64));   // repeated press overwrites the hold
    send_item(mk(ACT_CTRL, 7'd19, 7'd127));     // y up: octave jump retunes held notes
    send_item(mk(ACT_CTRL, 7'd19, 7'd40));      // hysteresis gap, nothing moves
    send_item(mk(ACT_CTRL, 7'd19, 7'd64));      // y back to centre, silent
    send_item(mk(ACT_CTRL, 7'd19, 7'd0));       // y down
    send_item(mk(ACT_CTRL, 7'd18, 7'd0));       // x held down
    send_item(mk(ACT_CTRL, 7'd18, 7'd90));      // x in the gap, no change
    send_item(mk(ACT_CTRL, 7'd18, 7'd64));      // x centre undoes the shift
    send_item(mk(ACT_CTRL, 7'd18, 7'd127));     // x held up
    send_item(mk(ACT_CTRL, 7'd18, 7'd49));      // x centre again
    send_item(mk(ACT_NOTE_ON, 7'd63, 7'd100));  // arm key mode
    send_item(mk(ACT_NOTE_ON, 7'd66, 7'd127));  // sets the key, retune
    send_item(mk(ACT_NOTE_OFF, 7'd66, 7'd0));   // release in a mode does nothing
    send_item(mk(ACT_NOTE_ON, 7'd62, 7'd127));  // lowest mode too, key mode still wins
    send_item(mk(ACT_NOTE_ON, 7'd75, 7'd127));  // key back to zero
    send_item(mk(ACT_NOTE_ON, 7'd63, 7'd0));    // key mode off by zero velocity
    send_item(mk(ACT_NOTE_ON, 7'd70, 7'd127));  // sets the lowest degree
    send_item(mk(ACT_NOTE_OFF, 7'd62, 7'd127)); // lowest mode off
    send_item(mk(ACT_NOTE_OFF, 7'd64, 7'd127)); // release of a held note
    send_item(mk(ACT_NOTE_ON, 7'd70, 7'd0));    // release of a button never held
    send_item(mk(ACT_NOTE_ON, 7'd127, 7'd127)); // unmapped notes at both ends
    send_item(mk(ACT_NOTE_OFF, 7'd0, 7'd0));
    send_item(mk(ACT_CTRL, 7'd5, 7'd127));      // unmapped controller
    send_item(mk(ACT_UNUSED, 7'd64, 7'd127));   // unused action on a button number

    play_random(80);
    settle();

    // Buttons at the bottom of the range, register extremes elsewhere.
    apply_setup(7'd0, 7'd127, 7'd12, 7'd0, 7'd127);
    play_random(70);
    settle();

    // Buttons at the top; the key-mode number falls inside the button range,
    // so that number must behave as a button.
    apply_setup(7'd116, 7'd120, 7'd115, 7'd127, 7'd0);
    play_random(70);
    settle();

    // Random registers, with a long stretch where neither side idles.
    apply_setup(7'($urandom_range(0, 116)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)));
    calm <= 1'b1;
    play_random(50);
    calm <= 1'b0;
    play_random(20);
    settle();

    // Both mode buttons on one number and both axes on one controller:
    // key mode and the x axis take precedence.
    shared_note = 7'($urandom_range(0, 127));
    shared_ctrl = 7'($urandom_range(0, 127));
    apply_setup(7'($urandom_range(0, 116)), shared_note, shared_note, shared_ctrl, shared_ctrl);
    play_random(60);
    settle();

    $display("Drove %0d input transactions across %0d register setups.", sent_items, setups);
    $display("Checked %0d result transactions, %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0 && expected_left == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/sbnm_pkg.sv
sv/sbnm_cfg.sv
sv/sbnm_dp.sv
sv/sbnm_ctrl.sv
sv/scale_button_note_mapper.sv
bench/sbnm_checker.sv
bench/tb_top.sv
